// ===== rtl/core/qat_pkg.sv =====
package qat_pkg;

  // Result kinds carried on the output channel.
  typedef enum logic [1:0] {
    KIND_CHAR      = 2'd0,
    KIND_TOKEN_END = 2'd1,
    KIND_LINE_END  = 2'd2
  } qat_kind_t;

  // Grouping mode of the current token.
  typedef enum logic [1:0] {
    QM_NONE   = 2'd0,
    QM_DOUBLE = 2'd1,
    QM_SINGLE = 2'd2,
    QM_BRACE  = 2'd3
  } qat_qmode_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_COMMA_IS_DELIMITER = 2'd0;
  localparam logic [1:0] REG_IGNORE_QUOTES      = 2'd1;
  localparam logic [1:0] REG_BRACES_GROUP       = 2'd2;
  localparam logic [1:0] REG_STRIP_BRACKETS     = 2'd3;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 1;

  // Character codes with a special meaning.
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DQUOTE = 8'd34;
  localparam logic [7:0] CH_HASH   = 8'd35;
  localparam logic [7:0] CH_SQUOTE = 8'd39;
  localparam logic [7:0] CH_LPAREN = 8'd40;
  localparam logic [7:0] CH_RPAREN = 8'd41;
  localparam logic [7:0] CH_COMMA  = 8'd44;
  localparam logic [7:0] CH_LBRACE = 8'd123;
  localparam logic [7:0] CH_RBRACE = 8'd125;

  typedef struct packed {
    logic comma_is_delimiter;
    logic ignore_quotes;
    logic braces_group;
    logic strip_brackets;
  } qat_cfg_t;

  typedef struct packed {
    qat_qmode_t quote_mode;
    logic       token_nonempty;
    logic       had_quotes;
    logic       skip_rest;
  } qat_state_t;

  // All results caused by one character, in output order: char, token end, line end.
  typedef struct packed {
    logic       char_v;
    logic [7:0] char_val;
    logic       tend_v;
    logic       lend_v;
  } qat_bundle_t;

endpackage

// ===== rtl/core/qat_in_if.sv =====
interface qat_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_last;

  modport source (output valid, output ch, output line_last, input ready);
  modport sink (input valid, input ch, input line_last, output ready);
endinterface

// ===== rtl/core/qat_out_if.sv =====
interface qat_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, output kind, output out_char, output last, input ready);
  modport sink (input valid, input kind, input out_char, input last, output ready);
endinterface

// ===== rtl/core/qat_step.sv =====
module qat_step (
  input  qat_pkg::qat_cfg_t    cfg,
  input  qat_pkg::qat_state_t  state,
  input  logic [7:0]           ch,
  input  logic                 line_last,
  output qat_pkg::qat_state_t  state_nxt,
  output qat_pkg::qat_bundle_t bundle
);

  logic               keep;
  logic               done;
  logic               eol;
  logic               delim;
  qat_pkg::qat_qmode_t qcode;
  qat_pkg::qat_qmode_t qm_nxt;
  logic               tn_nxt;
  logic               hq_nxt;
  logic               skip_nxt;
  logic               tend;

  assign qcode = (ch == qat_pkg::CH_DQUOTE) ? qat_pkg::QM_DOUBLE : qat_pkg::QM_SINGLE;

  // Classify the character and update the grouping mode.
  always_comb begin
    keep   = 1'b0;
    done   = 1'b0;
    eol    = 1'b0;
    delim  = 1'b0;
    qm_nxt = state.quote_mode;
    hq_nxt = state.had_quotes;
    unique case (ch)
      qat_pkg::CH_LF, qat_pkg::CH_CR, qat_pkg::CH_HASH: begin
        done = 1'b1;
        eol  = 1'b1;
      end
      qat_pkg::CH_COMMA: begin
        if (cfg.comma_is_delimiter) delim = 1'b1;
        else keep = 1'b1;
      end
      qat_pkg::CH_TAB, qat_pkg::CH_SPACE: begin
        delim = 1'b1;
      end
      qat_pkg::CH_DQUOTE, qat_pkg::CH_SQUOTE: begin
        if (!cfg.ignore_quotes) begin
          if (state.quote_mode == qat_pkg::QM_NONE) begin
            qm_nxt = qcode;
          end else if (state.quote_mode == qcode) begin
            qm_nxt = qat_pkg::QM_NONE;
            hq_nxt = 1'b1;
            done   = 1'b1;
          end else begin
            keep = 1'b1;
          end
        end
      end
      qat_pkg::CH_LBRACE, qat_pkg::CH_RBRACE: begin
        if (!cfg.braces_group) begin
          keep = 1'b1;
        end else if (state.quote_mode == qat_pkg::QM_BRACE && ch == qat_pkg::CH_RBRACE) begin
          qm_nxt = qat_pkg::QM_NONE;
        end else begin
          keep = (state.quote_mode != qat_pkg::QM_NONE);
          if (ch == qat_pkg::CH_LBRACE) qm_nxt = qat_pkg::QM_BRACE;
        end
      end
      qat_pkg::CH_LPAREN, qat_pkg::CH_RPAREN: begin
        keep = !cfg.strip_brackets;
      end
      default: begin
        keep = 1'b1;
      end
    endcase
    // A delimiter inside a grouping is text; outside it closes a non-empty token.
    if (delim) begin
      if (state.quote_mode != qat_pkg::QM_NONE) keep = 1'b1;
      else if (state.token_nonempty) done = 1'b1;
    end
  end

  // Token and line bookkeeping.
  always_comb begin
    tn_nxt   = state.token_nonempty | keep;
    tend     = 1'b0;
    skip_nxt = state.skip_rest;
    state_nxt.quote_mode = qm_nxt;
    if (done || line_last) begin
      tend   = tn_nxt | hq_nxt;
      state_nxt.quote_mode = qat_pkg::QM_NONE;
      tn_nxt = 1'b0;
    end
    if (eol) skip_nxt = 1'b1;
    state_nxt.token_nonempty = tn_nxt;
    state_nxt.had_quotes     = (done || line_last) ? 1'b0 : hq_nxt;
    state_nxt.skip_rest      = skip_nxt;

    bundle.char_v   = keep;
    bundle.char_val = ch;
    bundle.tend_v   = tend;
    bundle.lend_v   = line_last;

    // The rest of a line after a hash, CR or LF gives only the line end.
    if (state.skip_rest) begin
      state_nxt      = state;
      bundle.char_v  = 1'b0;
      bundle.tend_v  = 1'b0;
    end
    if (line_last) begin
      state_nxt.quote_mode     = qat_pkg::QM_NONE;
      state_nxt.token_nonempty = 1'b0;
      state_nxt.had_quotes     = 1'b0;
      state_nxt.skip_rest      = 1'b0;
    end
  end

endmodule

// ===== rtl/core/quoted_argument_tokenizer_unit.sv =====
// Channel   Dir  Payload                          Beat when
// in_beat   in   ch[7:0], line_last               valid && ready
// out_beat  out  kind[1:0], out_char[7:0], last   valid && ready
// cfg_*     in   cfg_idx[1:0], cfg_wdata[0]       cfg_we
//
// One character enters per cycle while in_beat.ready is high; it is decoded in the cycle
// after it is taken. A character gives zero to three result beats, sent one per cycle
// from the result register while out_beat.ready is high. Its results hold the result
// register until the last is sent, and the next character waits in the input register.
// A character passes the input register, then the result register, before its first beat.
// Reset (rst_n low, synchronous) clears all flags and configuration registers.
// A stalled output fills the result register, then the input register, then lowers in ready.
module quoted_argument_tokenizer_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  qat_in_if.sink                              in_beat,
  qat_out_if.source                           out_beat,
  input  logic                                cfg_we,
  input  logic [qat_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [qat_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  qat_pkg::qat_cfg_t    cfg_r;
  qat_pkg::qat_state_t  state_r;
  qat_pkg::qat_state_t  state_nxt;
  qat_pkg::qat_bundle_t bundle_r;
  qat_pkg::qat_bundle_t bundle_nxt;
  qat_pkg::qat_bundle_t bundle_new;
  qat_pkg::qat_bundle_t bundle_pop;

  logic       s1_valid_r;
  logic [7:0] s1_ch_r;
  logic       s1_last_r;
  logic       in_fire;
  logic       out_fire;
  logic       bundle_empty;
  logic       pop_empty;
  logic       move;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        qat_pkg::REG_COMMA_IS_DELIMITER: cfg_r.comma_is_delimiter <= cfg_wdata[0];
        qat_pkg::REG_IGNORE_QUOTES:      cfg_r.ignore_quotes      <= cfg_wdata[0];
        qat_pkg::REG_BRACES_GROUP:       cfg_r.braces_group       <= cfg_wdata[0];
        qat_pkg::REG_STRIP_BRACKETS:     cfg_r.strip_brackets     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Result register drain: remove the leading result on each output beat.
  always_comb begin
    bundle_pop = bundle_r;
    if (bundle_r.char_v) bundle_pop.char_v = 1'b0;
    else if (bundle_r.tend_v) bundle_pop.tend_v = 1'b0;
    else bundle_pop.lend_v = 1'b0;
  end

  assign bundle_empty = !(bundle_r.char_v | bundle_r.tend_v | bundle_r.lend_v);
  assign pop_empty    = !(bundle_pop.char_v | bundle_pop.tend_v | bundle_pop.lend_v);
  assign out_fire     = out_beat.valid & out_beat.ready;
  assign move         = s1_valid_r & (bundle_empty | (out_fire & pop_empty));
  assign in_fire      = in_beat.valid & in_beat.ready;
  assign in_beat.ready = !s1_valid_r | move;

  qat_step u_step (
    .cfg       (cfg_r),
    .state     (state_r),
    .ch        (s1_ch_r),
    .line_last (s1_last_r),
    .state_nxt (state_nxt),
    .bundle    (bundle_new)
  );

  always_comb begin
    bundle_nxt = bundle_r;
    if (move) bundle_nxt = bundle_new;
    else if (out_fire) bundle_nxt = bundle_pop;
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ch_r   <= in_beat.ch;
      s1_last_r <= in_beat.line_last;
    end
  end

  // Tokenizer state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= '0;
      bundle_r <= '0;
    end else begin
      if (move) state_r <= state_nxt;
      bundle_r <= bundle_nxt;
    end
  end

  // Output beat selection.
  always_comb begin
    out_beat.valid    = !bundle_empty;
    out_beat.last     = pop_empty;
    out_beat.kind     = qat_pkg::KIND_LINE_END;
    out_beat.out_char = 8'd0;
    priority if (bundle_r.char_v) begin
      out_beat.kind     = qat_pkg::KIND_CHAR;
      out_beat.out_char = bundle_r.char_val;
    end else if (bundle_r.tend_v) begin
      out_beat.kind = qat_pkg::KIND_TOKEN_END;
    end else begin
      out_beat.kind = qat_pkg::KIND_LINE_END;
    end
  end

endmodule

// ===== rtl/core/qat_checker.sv =====
module qat_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_char,
  input logic       out_last
);

  // Only character beats carry a character.
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != qat_pkg::KIND_CHAR |-> out_char == 8'd0)
    else $error("non-character beat carries a character");

  // A line end is always the final result of its character.
  a_lend_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == qat_pkg::KIND_LINE_END |-> out_last)
    else $error("line end beat without last");

  // A character beat that is not last is followed by a token end beat.
  a_char_then_tend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_kind == qat_pkg::KIND_CHAR && !out_last
    |=> out_valid && out_kind == qat_pkg::KIND_TOKEN_END)
    else $error("character beat not followed by token end");

  // A stalled beat holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_char)
      && $stable(out_last))
    else $error("stalled output beat changed");

  // No beat is offered in the cycle after reset.
  a_reset: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind quoted_argument_tokenizer_unit qat_checker u_qat_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_beat.valid),
  .out_ready (out_beat.ready),
  .out_kind  (out_beat.kind),
  .out_char  (out_beat.out_char),
  .out_last  (out_beat.last)
);

// ===== tb/quoted_argument_tokenizer_unit_test.sv =====
module quoted_argument_tokenizer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // One result beat as seen on the output channel.
  typedef struct packed {
    qat_pkg::qat_kind_t kind;
    logic [7:0]         out_char;
    logic               last;
  } tok_result_t;

  // Directed line script: either a character or a full register update.
  typedef enum logic {
    SCRIPT_CHAR,
    SCRIPT_SET_CFG
  } script_op_t;

  typedef struct packed {
    script_op_t                  op;
    logic [7:0]                  ch;
    logic                        line_last;
    qat_pkg::qat_cfg_t           cfg;
    logic                        known;
    logic [1:0]                  n_known;
    qat_pkg::qat_kind_t [0:2]    kinds;
  } script_entry_t;

  typedef enum int {
    PH_STEADY,
    PH_SPARSE_SEND,
    PH_SLOW_DRAIN,
    PH_MIXED,
    PH_BACKPRESSURE
  } traffic_phase_t;

  localparam int LINE_CHARS_PER_PHASE = 20;
  localparam int SETTLE_CYCLES        = 8;
  localparam int HOLD_OFF_CYCLES      = 80;

  localparam qat_pkg::qat_kind_t [0:2] K_CHAR =
    '{qat_pkg::KIND_CHAR, qat_pkg::KIND_CHAR, qat_pkg::KIND_CHAR};
  localparam qat_pkg::qat_kind_t [0:2] K_TEND =
    '{qat_pkg::KIND_TOKEN_END, qat_pkg::KIND_CHAR, qat_pkg::KIND_CHAR};
  localparam qat_pkg::qat_kind_t [0:2] K_LEND =
    '{qat_pkg::KIND_LINE_END, qat_pkg::KIND_CHAR, qat_pkg::KIND_CHAR};
  localparam qat_pkg::qat_kind_t [0:2] K_TEND_LEND =
    '{qat_pkg::KIND_TOKEN_END, qat_pkg::KIND_LINE_END, qat_pkg::KIND_CHAR};
  localparam qat_pkg::qat_kind_t [0:2] K_ALL =
    '{qat_pkg::KIND_CHAR, qat_pkg::KIND_TOKEN_END, qat_pkg::KIND_LINE_END};

  localparam int SCRIPT_LEN = 30;

  // Expected results are typed in where they are obvious; the rest are predicted.
  localparam script_entry_t LINE_SCRIPT [SCRIPT_LEN] = '{
    '{SCRIPT_CHAR, "a",                1'b0, '0, 1'b1, 2'd1, K_CHAR},
    '{SCRIPT_CHAR, 8'h00,              1'b0, '0, 1'b1, 2'd1, K_CHAR},
    '{SCRIPT_CHAR, 8'hFF,              1'b0, '0, 1'b1, 2'd1, K_CHAR},
    '{SCRIPT_CHAR, qat_pkg::CH_SPACE,  1'b0, '0, 1'b1, 2'd1, K_TEND},
    '{SCRIPT_CHAR, qat_pkg::CH_DQUOTE, 1'b0, '0, 1'b1, 2'd0, K_CHAR},
    '{SCRIPT_CHAR, qat_pkg::CH_DQUOTE, 1'b0, '0, 1'b1, 2'd1, K_TEND},
    '{SCRIPT_CHAR, qat_pkg::CH_SQUOTE, 1'b0, '0, 1'b1, 2'd0, K_CHAR},
    '{SCRIPT_CHAR, qat_pkg::CH_DQUOTE, 1'b0, '0, 1'b0, 2'd0, K_CHAR},
    '{SCRIPT_CHAR, qat_pkg::CH_SPACE,  1'b0, '0, 1'b0, 2'd0, K_CHAR},
    '{SCRIPT_CHAR, "x",                1'b1, '0, 1'b1, 2'd3, K_ALL},
    '{SCRIPT_CHAR, qat_pkg::CH_HASH,   1'b0, '0, 1'b1, 2'd0, K_CHAR},
    '{SCRIPT_CHAR, "z",                1'b0, '0, 1'b1, 2'd0, K_CHAR},
    '{SCRIPT_CHAR, "q",                1'b1, '0, 1'b1, 2'd1, K_LEND},
    '{SCRIPT_CHAR, qat_pkg::CH_LPAREN, 1'b0, '0, 1'b0, 2'd0, K_CHAR},
    '{SCRIPT_CHAR, qat_pkg::CH_LBRACE, 1'b0, '0, 1'b0, 2'd0, K_CHAR},
    '{SCRIPT_CHAR, qat_pkg::CH_COMMA,  1'b0, '0, 1'b0, 2'd0, K_CHAR},
    '{SCRIPT_CHAR, qat_pkg::CH_TAB,    1'b0, '0, 1'b1, 2'd1, K_TEND},
    '{SCRIPT_CHAR, qat_pkg::CH_CR,     1'b0, '0, 1'b1, 2'd0, K_CHAR},
    '{SCRIPT_CHAR, qat_pkg::CH_LF,     1'b1, '0, 1'b1, 2'd1, K_LEND},
    '{SCRIPT_CHAR, "b",                1'b0, '0, 1'b0, 2'd0, K_CHAR},
    '{SCRIPT_CHAR, qat_pkg::CH_LF,     1'b1, '0, 1'b1, 2'd2, K_TEND_LEND},
    '{SCRIPT_SET_CFG, 8'h00,           1'b0, 4'b1111, 1'b0, 2'd0, K_CHAR},
    '{SCRIPT_CHAR, qat_pkg::CH_LPAREN, 1'b0, '0, 1'b0, 2'd0, K_CHAR},
    '{SCRIPT_CHAR, qat_pkg::CH_LBRACE, 1'b0, '0, 1'b0, 2'd0, K_CHAR},
    '{SCRIPT_CHAR, qat_pkg::CH_COMMA,  1'b0, '0, 1'b0, 2'd0, K_CHAR},
    '{SCRIPT_CHAR, qat_pkg::CH_LBRACE, 1'b0, '0, 1'b0, 2'd0, K_CHAR},
    '{SCRIPT_CHAR, qat_pkg::CH_RBRACE, 1'b0, '0, 1'b0, 2'd0, K_CHAR},
    '{SCRIPT_CHAR, qat_pkg::CH_DQUOTE, 1'b0, '0, 1'b0, 2'd0, K_CHAR},
    '{SCRIPT_CHAR, qat_pkg::CH_RPAREN, 1'b0, '0, 1'b0, 2'd0, K_CHAR},
    '{SCRIPT_CHAR, qat_pkg::CH_COMMA,  1'b1, '0, 1'b0, 2'd0, K_CHAR}
  };

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [qat_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [qat_pkg::CFG_DATA_W-1:0] cfg_wdata;

  qat_in_if  in_if ();
  qat_out_if out_if ();

  quoted_argument_tokenizer_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_if),
    .out_beat (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // Mirror of the tokenizer state and its registers.
  qat_pkg::qat_cfg_t   mirror_cfg   = '0;
  qat_pkg::qat_qmode_t group_mode   = qat_pkg::QM_NONE;
  logic                tok_nonempty = 1'b0;
  logic                tok_quoted   = 1'b0;
  logic                skip_line    = 1'b0;

  tok_result_t char_results [3];
  int          char_result_cnt;

  tok_result_t pending_results [$];
  logic [7:0]  line_buf [$];
  int          mismatches = 0;
  int          chars_sent = 0;
  int          gap_pct    = 0;
  int          stall_pct  = 0;
  logic        rx_hold    = 1'b0;

  // Appends one expectation to the tail of the scoreboard.
  function automatic void queue_expected(input tok_result_t r);
    pending_results = {pending_results, r};
  endfunction

  // Appends one character to the line being built.
  function automatic void add_line_char(input logic [7:0] c);
    line_buf = {line_buf, c};
  endfunction

  function automatic void add_result(input qat_pkg::qat_kind_t kind, input logic [7:0] c);
    char_results[char_result_cnt] = '{kind, c, 1'b0};
    char_result_cnt++;
  endfunction

  function automatic void keep_char(input logic [7:0] c);
    tok_nonempty = 1'b1;
    add_result(qat_pkg::KIND_CHAR, c);
  endfunction

  // Works out the results of one character and advances the mirrored state.
  function automatic void tokenize_char(input logic [7:0] c, input logic line_last);
    logic                done;
    logic                eol;
    logic                delim;
    qat_pkg::qat_qmode_t code;
    done = 1'b0;
    eol = 1'b0;
    delim = 1'b0;
    char_result_cnt = 0;
    if (!skip_line) begin
      case (c)
        qat_pkg::CH_LF, qat_pkg::CH_CR, qat_pkg::CH_HASH: begin
          done = 1'b1;
          eol = 1'b1;
        end
        qat_pkg::CH_COMMA: begin
          if (mirror_cfg.comma_is_delimiter) delim = 1'b1;
          else keep_char(c);
        end
        qat_pkg::CH_TAB, qat_pkg::CH_SPACE: begin
          delim = 1'b1;
        end
        qat_pkg::CH_DQUOTE, qat_pkg::CH_SQUOTE: begin
          code = (c == qat_pkg::CH_DQUOTE) ? qat_pkg::QM_DOUBLE : qat_pkg::QM_SINGLE;
          if (!mirror_cfg.ignore_quotes) begin
            if (group_mode == qat_pkg::QM_NONE) begin
              group_mode = code;
            end else if (group_mode == code) begin
              group_mode = qat_pkg::QM_NONE;
              tok_quoted = 1'b1;
              done = 1'b1;
            end else begin
              keep_char(c);
            end
          end
        end
        qat_pkg::CH_LBRACE, qat_pkg::CH_RBRACE: begin
          if (!mirror_cfg.braces_group) begin
            keep_char(c);
          end else if (group_mode == qat_pkg::QM_BRACE && c == qat_pkg::CH_RBRACE) begin
            group_mode = qat_pkg::QM_NONE;
          end else begin
            if (group_mode != qat_pkg::QM_NONE) keep_char(c);
            if (c == qat_pkg::CH_LBRACE) group_mode = qat_pkg::QM_BRACE;
          end
        end
        qat_pkg::CH_LPAREN, qat_pkg::CH_RPAREN: begin
          if (!mirror_cfg.strip_brackets) keep_char(c);
        end
        default: begin
          keep_char(c);
        end
      endcase

      // A delimiter inside a group is text; outside it closes a non-empty token.
      if (delim) begin
        if (group_mode != qat_pkg::QM_NONE) keep_char(c);
        else if (tok_nonempty) done = 1'b1;
      end

      if (done || line_last) begin
        if (tok_nonempty || tok_quoted) add_result(qat_pkg::KIND_TOKEN_END, 8'h00);
        tok_nonempty = 1'b0;
        tok_quoted = 1'b0;
        group_mode = qat_pkg::QM_NONE;
      end
      if (eol) skip_line = 1'b1;
    end

    if (line_last) begin
      add_result(qat_pkg::KIND_LINE_END, 8'h00);
      group_mode = qat_pkg::QM_NONE;
      tok_nonempty = 1'b0;
      tok_quoted = 1'b0;
      skip_line = 1'b0;
    end

    if (char_result_cnt > 0) char_results[char_result_cnt - 1].last = 1'b1;
  endfunction

  // Offers one character, waits for its beat, then records what it should cause.
  task automatic send_char(input logic [7:0] c, input logic line_last, input bit use_prediction);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.ch <= c;
    in_if.line_last <= line_last;
    do @(posedge clk); while (!in_if.ready);
    tokenize_char(c, line_last);
    if (use_prediction) begin
      for (int k = 0; k < char_result_cnt; k++) queue_expected(char_results[k]);
    end
    chars_sent++;
  endtask

  // Stops offering and waits until the block has nothing left in flight.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [qat_pkg::CFG_IDX_W-1:0] idx, input logic val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_cfg(input qat_pkg::qat_cfg_t c);
    write_reg(qat_pkg::REG_COMMA_IS_DELIMITER, c.comma_is_delimiter);
    write_reg(qat_pkg::REG_IGNORE_QUOTES, c.ignore_quotes);
    write_reg(qat_pkg::REG_BRACES_GROUP, c.braces_group);
    write_reg(qat_pkg::REG_STRIP_BRACKETS, c.strip_brackets);
    cfg_we <= 1'b0;
    mirror_cfg = c;
  endtask

  function automatic logic [7:0] word_char();
    if ($urandom_range(0, 3) == 0) return 8'("0" + $urandom_range(0, 9));
    return 8'("a" + $urandom_range(0, 25));
  endfunction

  // Text inside a group: mostly plain, sometimes a character with a meaning.
  function automatic logic [7:0] group_char();
    logic [7:0] specials [9] = '{qat_pkg::CH_SPACE, qat_pkg::CH_TAB, qat_pkg::CH_COMMA,
                                 qat_pkg::CH_DQUOTE, qat_pkg::CH_SQUOTE, qat_pkg::CH_LBRACE,
                                 qat_pkg::CH_RBRACE, qat_pkg::CH_LPAREN, qat_pkg::CH_RPAREN};
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 12) return word_char();
    if (pick < 18) return specials[$urandom_range(0, 8)];
    return 8'($urandom_range(0, 255));
  endfunction

  // Builds one line of words, groups, separators and noise, then sends it.
  task automatic send_random_line();
    logic [7:0] delims [3] = '{qat_pkg::CH_SPACE, qat_pkg::CH_TAB, qat_pkg::CH_COMMA};
    logic [7:0] stray [3] = '{qat_pkg::CH_RBRACE, qat_pkg::CH_DQUOTE, qat_pkg::CH_SQUOTE};
    logic [7:0] enders [3] = '{qat_pkg::CH_HASH, qat_pkg::CH_CR, qat_pkg::CH_LF};
    logic [7:0] opener;
    logic [7:0] closer;
    int pieces;
    line_buf.delete();
    pieces = $urandom_range(1, 4);
    for (int i = 0; i < pieces; i++) begin
      if (i > 0 || $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2)) add_line_char(delims[$urandom_range(0, 2)]);
      end
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          repeat ($urandom_range(1, 4)) add_line_char(word_char());
        end
        3, 4, 5: begin
          case ($urandom_range(0, 2))
            0: begin
              opener = qat_pkg::CH_DQUOTE;
              closer = qat_pkg::CH_DQUOTE;
            end
            1: begin
              opener = qat_pkg::CH_SQUOTE;
              closer = qat_pkg::CH_SQUOTE;
            end
            default: begin
              opener = qat_pkg::CH_LBRACE;
              closer = qat_pkg::CH_RBRACE;
            end
          endcase
          add_line_char(opener);
          repeat ($urandom_range(0, 4)) add_line_char(group_char());
          // Now and then the group is left open to the end of the line.
          if ($urandom_range(0, 7) != 0) add_line_char(closer);
        end
        6: begin
          add_line_char(qat_pkg::CH_LPAREN);
          repeat ($urandom_range(0, 3)) add_line_char(word_char());
          add_line_char(qat_pkg::CH_RPAREN);
        end
        7: begin
          repeat ($urandom_range(1, 3)) add_line_char(8'($urandom_range(0, 255)));
        end
        8: begin
          opener = $urandom_range(0, 1) ? qat_pkg::CH_DQUOTE : qat_pkg::CH_SQUOTE;
          add_line_char(opener);
          add_line_char(opener);
        end
        default: begin
          add_line_char(word_char());
          add_line_char(stray[$urandom_range(0, 2)]);
        end
      endcase
    end

    // Some lines end in a comment or an early line break with junk after it.
    if ($urandom_range(0, 5) == 0) begin
      add_line_char(enders[$urandom_range(0, 2)]);
      repeat ($urandom_range(0, 3)) add_line_char(8'($urandom_range(0, 255)));
    end

    foreach (line_buf[k]) send_char(line_buf[k], k == line_buf.size() - 1, 1'b1);
  endtask

  // Result side: checks each beat against the oldest expectation.
  task automatic check_result();
    tok_result_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected result: kind=%0d out_char=%0h last=%0b",
             out_if.kind, out_if.out_char, out_if.last);
      mismatches++;
    end else begin
      want = pending_results.pop_front();
      if (out_if.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, out_if.kind);
        mismatches++;
      end
      if (out_if.out_char !== want.out_char) begin
        $error("out_char: expected %0h, got %0h", want.out_char, out_if.out_char);
        mismatches++;
      end
      if (out_if.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, out_if.last);
        mismatches++;
      end
    end
  endtask

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) check_result();
      if (!rst_n || rx_hold) out_if.ready <= 1'b0;
      else out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    #1_000_000;
    $display("[quoted_argument_tokenizer_unit] ERROR");
    $finish;
  end

  initial begin
    tok_result_t       typed_res;
    script_entry_t     entry;
    qat_pkg::qat_cfg_t next_cfg;
    int                phase_goal;

    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.ch <= 8'h00;
    in_if.line_last <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= qat_pkg::REG_COMMA_IS_DELIMITER;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines: extremes, grouping corners and line-end handling.
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      entry = LINE_SCRIPT[i];
      if (entry.op == SCRIPT_SET_CFG) begin
        settle();
        load_cfg(entry.cfg);
      end else begin
        send_char(entry.ch, entry.line_last, !entry.known);
        if (entry.known) begin
          for (int k = 0; k < entry.n_known; k++) begin
            typed_res.kind = entry.kinds[k];
            typed_res.out_char = (entry.kinds[k] == qat_pkg::KIND_CHAR) ? entry.ch : 8'h00;
            typed_res.last = (k == entry.n_known - 1);
            queue_expected(typed_res);
          end
        end
      end
    end

    // Random lines under several register settings and traffic patterns.
    for (int p = PH_STEADY; p <= PH_BACKPRESSURE; p++) begin
      settle();
      case (traffic_phase_t'(p))
        PH_STEADY: begin
          next_cfg = '0;
          gap_pct = 0;
          stall_pct <= 0;
        end
        PH_SPARSE_SEND: begin
          next_cfg = '1;
          gap_pct = 87;
          stall_pct <= 0;
        end
        PH_SLOW_DRAIN: begin
          next_cfg = qat_pkg::qat_cfg_t'(4'($urandom_range(0, 15)));
          gap_pct = 0;
          stall_pct <= 87;
        end
        PH_MIXED: begin
          next_cfg = qat_pkg::qat_cfg_t'(4'($urandom_range(0, 15)));
          gap_pct = 28;
          stall_pct <= 28;
        end
        default: begin
          next_cfg = qat_pkg::qat_cfg_t'(4'($urandom_range(0, 15)));
          gap_pct = 0;
          stall_pct <= 0;
        end
      endcase
      load_cfg(next_cfg);

      // The receiver holds off long enough for the block to fill and stall its input.
      if (traffic_phase_t'(p) == PH_BACKPRESSURE) begin
        fork
          begin
            rx_hold <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
          end
        join_none
      end

      phase_goal = chars_sent + LINE_CHARS_PER_PHASE;
      while (chars_sent < phase_goal) send_random_line();
    end

    settle();
    if (mismatches == 0) begin
      $display("[quoted_argument_tokenizer_unit] OK");
    end else begin
      $display("[quoted_argument_tokenizer_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/qat_pkg.sv
rtl/core/qat_in_if.sv
rtl/core/qat_out_if.sv
rtl/core/qat_step.sv
rtl/core/quoted_argument_tokenizer_unit.sv
rtl/core/qat_checker.sv
tb/quoted_argument_tokenizer_unit_test.sv
